>>> src/aes_ctr_pkg.sv
// shared types, constants and round functions of the aes-128 ctr cipher
package aes_ctr_pkg;

	localparam int unsigned QDepth = 2;
	localparam int unsigned Rounds = 10;

	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CfgKeyHi = 2'd0;
	localparam cfg_index_t CfgKeyLo = 2'd1;
	localparam cfg_index_t CfgIvHi  = 2'd2;
	localparam cfg_index_t CfgIvLo  = 2'd3;

	// one queued beat, classified by the front
	typedef struct packed {
		logic [7:0] data;
		logic       msg_start;
		logic       new_block;
		logic [3:0] pos;
	} entry_t;

	localparam logic [7:0] Sbox [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_double(input logic [7:0] x);
		gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k of the state sits at [127-8k -: 8], byte k = column k/4, row k%4
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (c * 4 + r) -: 8] = Sbox[s[127 - 8 * (((c + r) % 4) * 4 + r) -: 8]];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0  = s[127 - 32 * c -: 8];
			a1  = s[119 - 32 * c -: 8];
			a2  = s[111 - 32 * c -: 8];
			a3  = s[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
		end
		mix_cols = t;
	endfunction

	// next round key from the current one and its round constant
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w3r, t, w0, w1, w2, w3;
		w3r = {k[23:0], k[31:24]};
		t = {Sbox[w3r[31:24]] ^ rc, Sbox[w3r[23:16]], Sbox[w3r[15:8]], Sbox[w3r[7:0]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	endfunction

endpackage

>>> src/aes_ctr_front.sv
// input side: byte position tracking and a two-beat queue
module aes_ctr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 msg_start,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 q_valid,
	output aes_ctr_pkg::entry_t  q_entry,
	input  logic                 q_pop
);

	aes_ctr_pkg::entry_t mem_q [aes_ctr_pkg::QDepth];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [3:0] pos_q;
	logic [3:0] pos_now;
	logic       push;

	assign in_stall = (count_q == 2'(aes_ctr_pkg::QDepth));
	assign push     = in_valid && !in_stall;
	assign pos_now  = msg_start ? 4'd0 : pos_q;
	assign q_valid  = (count_q != 2'd0);
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: data_byte, msg_start: msg_start,
				new_block: (pos_now == 4'd0), pos: pos_now};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			pos_q    <= 4'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
				pos_q    <= pos_now + 4'd1;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> src/aes_ctr_back.sv
// execution side: key/iv registers, counter, iterative aes round unit, output register
module aes_ctr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 q_valid,
	input  aes_ctr_pkg::entry_t  q_entry,
	output logic                 q_pop,
	output logic [7:0]           out_byte,
	output logic                 out_valid,
	input  logic                 out_stall
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t       state_q;
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [127:0] key_q, ctr_q, blk_q, rk_q, ks_q;
	logic [7:0]   rc_q;
	logic [3:0]   round_q;
	logic         have_ks_q;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;

	logic         out_free, start;
	logic [127:0] key_use, ctr_use, rk_next, blk_sub;

	assign out_free = !out_valid_q || !out_stall;
	assign key_use  = q_entry.msg_start ? {key_hi_q, key_lo_q} : key_q;
	assign ctr_use  = q_entry.msg_start ? {iv_hi_q, iv_lo_q} : ctr_q;
	assign start    = (state_q == S_IDLE) && q_valid && q_entry.new_block && !have_ks_q;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free
		&& (!q_entry.new_block || have_ks_q);
	assign rk_next  = aes_ctr_pkg::next_key(rk_q, rc_q);
	assign blk_sub  = aes_ctr_pkg::sub_shift(blk_q);
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= '0;
			iv_lo_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aes_ctr_pkg::CfgKeyHi: key_hi_q <= cfg_data;
				aes_ctr_pkg::CfgKeyLo: key_lo_q <= cfg_data;
				aes_ctr_pkg::CfgIvHi:  iv_hi_q  <= cfg_data;
				aes_ctr_pkg::CfgIvLo:  iv_lo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			blk_q   <= ctr_use ^ key_use;
			rk_q    <= key_use;
			rc_q    <= 8'h01;
			round_q <= 4'd1;
		end else if (state_q == S_RUN) begin
			blk_q   <= ((round_q == 4'(aes_ctr_pkg::Rounds)) ? blk_sub
				: aes_ctr_pkg::mix_cols(blk_sub)) ^ rk_next;
			rk_q    <= rk_next;
			rc_q    <= aes_ctr_pkg::gf_double(rc_q);
			round_q <= round_q + 4'd1;
		end
		if (q_pop) begin
			out_byte_q <= q_entry.data
				^ (q_entry.new_block ? blk_q[127:120] : ks_q[127 - 8 * q_entry.pos -: 8]);
		end
		if (q_pop && q_entry.new_block) begin
			ks_q <= blk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_q       <= '0;
			ctr_q       <= '0;
			have_ks_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q   <= key_use;
						ctr_q   <= ctr_use + 128'd1;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (round_q == 4'(aes_ctr_pkg::Rounds)) begin
						have_ks_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (q_pop) begin
				have_ks_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/aes128_ctr_stream_cipher.sv
// AES-128 counter-mode byte cipher (encrypts and decrypts alike). Bytes inside a
// 16-byte block pass one per cycle unless the output stalls; the first byte of
// each block, and the byte that carries msg_start, waits while the single round
// unit runs the load step and ten AES rounds one per cycle, with round keys made
// on the fly from the key latched at message start. A two-beat input queue and an
// output register let both sides stall independently. Key and IV registers are
// read at message start only; write them while the block is idle.
module aes128_ctr_stream_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [7:0]  data_byte,
	input  logic        msg_start,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	input  logic        out_stall
);

	logic                q_valid, q_pop;
	aes_ctr_pkg::entry_t q_entry;

	aes_ctr_front u_front (
		.clk, .arst_n, .data_byte, .msg_start, .in_valid, .in_stall,
		.q_valid, .q_entry, .q_pop
	);

	aes_ctr_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_entry, .q_pop, .out_byte, .out_valid, .out_stall
	);

endmodule

>>> src/aes_ctr_checker.sv
// port-level checks of the ctr cipher, bound to the top level
module aes_ctr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] out_byte,
	input logic       out_valid,
	input logic       out_stall
);

	// a held result beat keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("output beat changed while stalled");

	// the queue only fills through an accepted beat
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted beat");

	// the queue drains only into the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("queue drained without a result beat");

endmodule

bind aes128_ctr_stream_cipher aes_ctr_checker u_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_byte, .out_valid, .out_stall
);

>>> tb/testbench.sv
// self-checking testbench for the aes-128 ctr byte cipher
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       typed;
		logic [7:0] want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = aes_ctr_pkg::CfgKeyHi;
	logic [63:0] cfg_data = '0;
	logic [7:0]  data_byte = '0;
	logic        msg_start = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;

	// predictor state
	logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [127:0] ctr_q;
	logic [127:0] ks_q;
	logic [3:0]   pos_q;
	logic [31:0]  rk_q [44];

	logic [7:0] cipher_bytes_q [$];
	int         errors = 0;
	int         beats_in = 0;
	int         beats_out = 0;
	int         messages = 0;
	bit         idle_on = 1'b1;

	aes128_ctr_stream_cipher DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.data_byte(data_byte), .msg_start(msg_start),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_byte(out_byte), .out_valid(out_valid), .out_stall(out_stall)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		rk_q[0] = key_hi_q[63:32];
		rk_q[1] = key_hi_q[31:0];
		rk_q[2] = key_lo_q[63:32];
		rk_q[3] = key_lo_q[31:0];
		for (int i = 4; i < 44; i++) begin
			t = rk_q[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aes_ctr_pkg::Sbox[t[31:24]] ^ rc, aes_ctr_pkg::Sbox[t[23:16]],
					aes_ctr_pkg::Sbox[t[15:8]], aes_ctr_pkg::Sbox[t[7:0]]};
				rc = xtime(rc);
			end
			rk_q[i] = rk_q[i - 4] ^ t;
		end
	endfunction

	// one aes-128 block encryption; byte k = column k/4, row k%4
	function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
		logic [7:0]  s [16];
		logic [7:0]  t [16];
		logic [7:0]  a0, a1, a2, a3, all;
		logic [31:0] w;
		logic [127:0] res;
		for (int k = 0; k < 16; k++) s[k] = blk[127 - 8 * k -: 8];
		for (int rnd = 0; rnd <= 10; rnd++) begin
			if (rnd > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						t[c * 4 + r] = aes_ctr_pkg::Sbox[s[((c + r) % 4) * 4 + r]];
				s = t;
			end
			if (rnd > 0 && rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[c * 4]; a1 = s[c * 4 + 1]; a2 = s[c * 4 + 2]; a3 = s[c * 4 + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					s[c * 4]     = a0 ^ all ^ xtime(a0 ^ a1);
					s[c * 4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
					s[c * 4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
					s[c * 4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
				end
			end
			for (int c = 0; c < 4; c++) begin
				w = rk_q[rnd * 4 + c];
				s[c * 4]     ^= w[31:24];
				s[c * 4 + 1] ^= w[23:16];
				s[c * 4 + 2] ^= w[15:8];
				s[c * 4 + 3] ^= w[7:0];
			end
		end
		for (int k = 0; k < 16; k++) res[127 - 8 * k -: 8] = s[k];
		return res;
	endfunction

	function automatic logic [7:0] cipher_byte(input logic [7:0] d, input logic start);
		logic [7:0] r;
		if (start) begin
			ctr_q = {iv_hi_q, iv_lo_q};
			pos_q = '0;
			expand_round_keys();
		end
		if (pos_q == 0) begin
			ks_q  = encrypt_block(ctr_q);
			ctr_q = ctr_q + 128'd1;
		end
		r = d ^ ks_q[127 - 8 * pos_q -: 8];
		pos_q = pos_q + 4'd1;
		return r;
	endfunction

	task automatic send_beat(input logic [7:0] d, input logic start,
			input logic typed, input logic [7:0] want);
		logic [7:0] pred;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		msg_start <= start;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = cipher_byte(d, start);
		cipher_bytes_q.push_back(typed ? want : pred);
		beats_in++;
		if (start) messages++;
	endtask

	// let every result out, then give the block time to settle
	task automatic drain();
		in_valid <= 1'b0;
		wait (cipher_bytes_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] khi, input logic [63:0] klo,
			input logic [63:0] vhi, input logic [63:0] vlo);
		logic [63:0] vals [4];
		vals = '{khi, klo, vhi, vlo};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= aes_ctr_pkg::cfg_index_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		key_hi_q = khi;
		key_lo_q = klo;
		iv_hi_q  = vhi;
		iv_lo_q  = vlo;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_traffic(input int quota, input bit pause_midway);
		int sent, len;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < quota) begin
			if (pause_midway && !paused && sent > quota / 2) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'b0, 8'h00);
				sent++;
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
					: $urandom_range(1, 40);
				for (int i = 0; i < len; i++)
					send_beat(8'($urandom_range(0, 255)),
						i == 0 && $urandom_range(0, 9) != 0, 1'b0, 8'h00);
				sent += len;
			end
		end
	endtask

	// receiver stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (cipher_bytes_q.size() == 0) begin
				$display("%t: unexpected beat, expected none, actual %h", $realtime, out_byte);
				errors++;
			end else begin
				if (out_byte !== cipher_bytes_q[0]) begin
					$display("%t: out_byte mismatch, expected %h, actual %h",
						$realtime, cipher_bytes_q[0], out_byte);
					errors++;
				end
				void'(cipher_bytes_q.pop_front());
			end
		end
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		stim_row_t rows [22];
		// zero key, zero counter: keystream starts 66 e9 4b d4 ...
		rows = '{
			'{8'h00, 1'b0, 1'b1, 8'h66}, '{8'h00, 1'b0, 1'b1, 8'he9},
			'{8'hff, 1'b0, 1'b1, 8'hb4}, '{8'h00, 1'b0, 1'b1, 8'hd4},
			'{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00},
			'{8'h7f, 1'b0, 1'b0, 8'h00}, '{8'hfe, 1'b0, 1'b0, 8'h00},
			'{8'h55, 1'b0, 1'b0, 8'h00}, '{8'haa, 1'b0, 1'b0, 8'h00},
			'{8'h00, 1'b0, 1'b0, 8'h00}, '{8'hff, 1'b0, 1'b0, 8'h00},
			'{8'h0f, 1'b0, 1'b0, 8'h00}, '{8'hf0, 1'b0, 1'b0, 8'h00},
			'{8'h3c, 1'b0, 1'b0, 8'h00}, '{8'hc3, 1'b0, 1'b0, 8'h00},
			'{8'h00, 1'b0, 1'b0, 8'h00}, '{8'hff, 1'b0, 1'b0, 8'h00},
			'{8'h00, 1'b1, 1'b1, 8'h66}, '{8'h00, 1'b0, 1'b1, 8'he9},
			'{8'h12, 1'b1, 1'b0, 8'h00}, '{8'hff, 1'b1, 1'b0, 8'h00}
		};
		key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
		ctr_q = '0; ks_q = '0; pos_q = '0;
		expand_round_keys();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any message start run on the reset key and counter
		foreach (rows[i]) send_beat(rows[i].data, rows[i].start, rows[i].typed, rows[i].want);
		drain();

		// all ones: counter wraps to zero after the first block
		load_regs('1, '1, '1, '1);
		for (int i = 0; i < 40; i++)
			send_beat(8'($urandom_range(0, 255)), i == 0, 1'b0, 8'h00);
		random_traffic(330, 1'b1);
		drain();

		// low half all ones: increment carries into the high half
		load_regs('0, '1, rand64(), '1);
		random_traffic(360, 1'b0);
		drain();

		load_regs(rand64(), rand64(), rand64(), rand64());
		random_traffic(360, 1'b0);
		drain();

		idle_on = 1'b0;
		load_regs(rand64(), '0, '0, rand64());
		random_traffic(340, 1'b0);
		drain();

		$display("sent %0d beats in %0d messages, received %0d beats",
			beats_in, messages, beats_out);
		$display("covered reset key, counter wrap, carry into high half, random keys");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> aes128_ctr_stream_cipher.f
src/aes_ctr_pkg.sv
src/aes_ctr_front.sv
src/aes_ctr_back.sv
src/aes128_ctr_stream_cipher.sv
src/aes_ctr_checker.sv
tb/testbench.sv
